// ===== rtl/core/vcec_pkg.sv =====
// Package for the voxel cluster extent and centroid core.
// Holds sizes, word types and the configuration register indexes; no dependencies.
`timescale 1ns / 1ps
package vcec_pkg;
  localparam int MaxVoxels = 1024;
  localparam int CoordBits = 12;
  localparam int FracBits  = 8;
  localparam int AddrBits  = $clog2(MaxVoxels);
  localparam int CountBits = AddrBits + 1;
  localparam int CentBits  = CoordBits + FracBits;
  localparam int SumBits   = CoordBits + CountBits;
  localparam int NumBits   = SumBits + FracBits;
  localparam int CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_BOX_X_LOW  = 3'd0,
    REG_BOX_X_HIGH = 3'd1,
    REG_BOX_Y_LOW  = 3'd2,
    REG_BOX_Y_HIGH = 3'd3,
    REG_BOX_Z_LOW  = 3'd4,
    REG_BOX_Z_HIGH = 3'd5,
    REG_LIMIT_EN   = 3'd6,
    REG_STRIP_LEN  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [CoordBits-1:0] voxel_x;
    logic [CoordBits-1:0] voxel_y;
    logic [CoordBits-1:0] voxel_z;
    logic                 last_voxel;
  } in_word_t;

  typedef struct packed {
    logic                 result_kind;
    logic [CentBits-1:0]  centroid_x;
    logic [CentBits-1:0]  centroid_y;
    logic [CentBits-1:0]  centroid_z;
    logic [CountBits-1:0] voxels_used;
    logic [CoordBits-1:0] extent_x_low;
    logic [CoordBits-1:0] extent_x_high;
    logic [CoordBits-1:0] extent_y_low;
    logic [CoordBits-1:0] extent_y_high;
    logic [CoordBits-1:0] extent_z_low;
    logic [CoordBits-1:0] extent_z_high;
    logic                 final_result;
  } out_word_t;

  typedef struct packed {
    logic [CoordBits-1:0] box_x_low;
    logic [CoordBits-1:0] box_x_high;
    logic [CoordBits-1:0] box_y_low;
    logic [CoordBits-1:0] box_y_high;
    logic [CoordBits-1:0] box_z_low;
    logic [CoordBits-1:0] box_z_high;
    logic [1:0]           limit_enables;
    logic [CoordBits-1:0] strip_length;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // store the input word, widen extents
    logic scan_start; // clear sums, set read address 0
    logic scan_step;  // read next entry
    logic acc_en;     // accumulate the entry read last cycle
    logic kind;       // 0 box, 1 strip
    logic div_start;  // launch the three divisions
    logic clear;      // end of cluster
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // address at last stored entry
    logic div_done;
  } dp_stat_t;
endpackage

// ===== rtl/core/voxel_cluster_extent_and_centroid_core.sv =====
// Voxel cluster extent and centroid core: input word in, two result words per cluster.
// Usage:
//   in_ channel: one voxel word per accepted cycle (in_valid high, in_stall low).
//   A word with last_voxel set closes the cluster; the core then stalls input,
//   scans the stored voxels once per result and divides each centroid axis.
//   out_ channel: result_kind 0 (box) then result_kind 1 (strip, final_result 1).
//   Loading: one voxel per cycle while no results are pending.
//   After the last voxel (N stored): per result, a scan of the N stored entries (one
//   memory read port), then a division of 31 quotient bits, one per cycle; out_valid
//   then rises. The strip result's scan starts once the box result is taken.
//   A result is held in the output register while out_stall is high; the core
//   does not start the next scan until it is taken.
//   Voxels beyond 1024 are dropped but last_voxel still closes the cluster.
//   cfg_ port: write registers only while idle, no read-back.
//   Reset (rst_n low, synchronous) empties the cluster and sets the box to the
//   full range, limits off, strip length 0. The voxel memory is not cleared.
// Depends on vcec_pkg, vcec_ctrl, vcec_datapath.
`timescale 1ns / 1ps
module voxel_cluster_extent_and_centroid_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vcec_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vcec_pkg::out_word_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [11:0]          cfg_wdata
);
  import vcec_pkg::*;
  cfg_t      cfg_r;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_word_t res, out_r;
  logic      out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{box_x_low: '0, box_x_high: '1, box_y_low: '0, box_y_high: '1,
                 box_z_low: '0, box_z_high: '1, limit_enables: '0, strip_length: '0};
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOX_X_LOW:  cfg_r.box_x_low  <= cfg_wdata;
        REG_BOX_X_HIGH: cfg_r.box_x_high <= cfg_wdata;
        REG_BOX_Y_LOW:  cfg_r.box_y_low  <= cfg_wdata;
        REG_BOX_Y_HIGH: cfg_r.box_y_high <= cfg_wdata;
        REG_BOX_Z_LOW:  cfg_r.box_z_low  <= cfg_wdata;
        REG_BOX_Z_HIGH: cfg_r.box_z_high <= cfg_wdata;
        REG_LIMIT_EN:   cfg_r.limit_enables <= cfg_wdata[1:0];
        REG_STRIP_LEN:  cfg_r.strip_length  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  vcec_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_last(in_data.last_voxel),
    .out_stall, .out_valid, .out_load, .stat, .cmd
  );

  vcec_datapath u_dp (
    .clk, .rst_n, .cfg(cfg_r), .in_word(in_data), .cmd, .stat, .res
  );

  always_ff @(posedge clk) begin
    if (out_load) out_r <= res;
  end

  assign out_data = out_r;
endmodule

// ===== rtl/core/vcec_div.sv =====
// Restoring divider, one quotient bit per cycle, for one centroid axis.
// Depends on vcec_pkg.
`timescale 1ns / 1ps
module vcec_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [vcec_pkg::NumBits-1:0]  numer,
  input  logic [vcec_pkg::CountBits-1:0] denom,
  output logic                          done,
  output logic [vcec_pkg::NumBits-1:0]  quot
);
  import vcec_pkg::*;
  localparam int StepBits = $clog2(NumBits + 1);
  logic [NumBits-1:0]   q_r, q_nxt;
  logic [CountBits:0]   rem_r, rem_nxt;
  logic [CountBits-1:0] den_r;
  logic [StepBits-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic [CountBits+1:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, q_r[NumBits-1]} - {2'b00, den_r};
    if (start) begin
      q_nxt = numer; rem_nxt = '0;
      cnt_nxt = StepBits'(NumBits); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[CountBits+1]) begin
        rem_nxt = trial[CountBits:0];
        q_nxt = {q_r[NumBits-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[CountBits-1:0], q_r[NumBits-1]};
        q_nxt = {q_r[NumBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == StepBits'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
    if (start) den_r <= denom;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

// ===== rtl/core/vcec_datapath.sv =====
// Datapath: voxel memory, extent tracking, scan accumulators and dividers.
// Depends on vcec_pkg and vcec_div.
`timescale 1ns / 1ps
module vcec_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  vcec_pkg::cfg_t      cfg,
  input  vcec_pkg::in_word_t  in_word,
  input  vcec_pkg::dp_cmd_t   cmd,
  output vcec_pkg::dp_stat_t  stat,
  output vcec_pkg::out_word_t res
);
  import vcec_pkg::*;
  localparam int MemBits = 3 * CoordBits;

  logic [MemBits-1:0]   mem [MaxVoxels];
  logic [MemBits-1:0]   rd_r;
  logic [CountBits-1:0] cnt_r;
  logic [AddrBits-1:0]  raddr_r;
  logic [CoordBits-1:0] xlo_r, xhi_r, ylo_r, yhi_r, zlo_r, zhi_r;
  logic [SumBits-1:0]   sx_r, sy_r, sz_r;
  logic [CountBits-1:0] n_r;
  logic                 full, first;
  logic [CoordBits-1:0] vx, vy, vz;
  logic [CoordBits:0]   strip_end;
  logic                 take;
  logic [2:0]           dv_done;
  logic [NumBits-1:0]   qx, qy, qz;

  assign full  = (cnt_r == CountBits'(MaxVoxels));
  assign first = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load && !full) mem[cnt_r[AddrBits-1:0]] <= {in_word.voxel_x, in_word.voxel_y,
                                                         in_word.voxel_z};
    rd_r <= mem[raddr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      cnt_r <= '0;
      xlo_r <= '0; xhi_r <= '0; ylo_r <= '0; yhi_r <= '0; zlo_r <= '0; zhi_r <= '0;
    end else if (cmd.load && !full) begin
      cnt_r <= cnt_r + 1'b1;
      if (first || in_word.voxel_x < xlo_r) xlo_r <= in_word.voxel_x;
      if (first || in_word.voxel_x > xhi_r) xhi_r <= in_word.voxel_x;
      if (first || in_word.voxel_y < ylo_r) ylo_r <= in_word.voxel_y;
      if (first || in_word.voxel_y > yhi_r) yhi_r <= in_word.voxel_y;
      if (first || in_word.voxel_z < zlo_r) zlo_r <= in_word.voxel_z;
      if (first || in_word.voxel_z > zhi_r) zhi_r <= in_word.voxel_z;
    end
  end

  assign {vx, vy, vz} = rd_r;
  assign strip_end = {1'b0, xlo_r} + {1'b0, cfg.strip_length};

  always_comb begin
    if (!cmd.kind) begin
      take = cfg.box_x_low <= vx && vx <= cfg.box_x_high;
      if (cfg.limit_enables[0]) take = take && cfg.box_y_low <= vy && vy <= cfg.box_y_high;
      if (cfg.limit_enables[1]) take = take && cfg.box_z_low <= vz && vz <= cfg.box_z_high;
    end else begin
      take = xlo_r <= vx && {1'b0, vx} <= strip_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) raddr_r <= '0;
    else if (cmd.scan_step) raddr_r <= raddr_r + 1'b1;
    if (cmd.scan_start) begin
      sx_r <= '0; sy_r <= '0; sz_r <= '0; n_r <= '0;
    end else if (cmd.acc_en && take) begin
      sx_r <= sx_r + SumBits'(vx);
      sy_r <= sy_r + SumBits'(vy);
      sz_r <= sz_r + SumBits'(vz);
      n_r  <= n_r + 1'b1;
    end
  end

  vcec_div u_div_x (.clk, .rst_n, .start(cmd.div_start), .numer({sx_r, FracBits'(0)}),
                    .denom(n_r), .done(dv_done[0]), .quot(qx));
  vcec_div u_div_y (.clk, .rst_n, .start(cmd.div_start), .numer({sy_r, FracBits'(0)}),
                    .denom(n_r), .done(dv_done[1]), .quot(qy));
  vcec_div u_div_z (.clk, .rst_n, .start(cmd.div_start), .numer({sz_r, FracBits'(0)}),
                    .denom(n_r), .done(dv_done[2]), .quot(qz));

  assign stat.scan_last = ({1'b0, raddr_r} == cnt_r - 1'b1);
  assign stat.div_done  = &dv_done;

  always_comb begin
    res.result_kind   = cmd.kind;
    res.centroid_x    = (n_r == '0) ? '0 : qx[CentBits-1:0];
    res.centroid_y    = (n_r == '0) ? '0 : qy[CentBits-1:0];
    res.centroid_z    = (n_r == '0) ? '0 : qz[CentBits-1:0];
    res.voxels_used   = n_r;
    res.extent_x_low  = xlo_r;
    res.extent_x_high = xhi_r;
    res.extent_y_low  = ylo_r;
    res.extent_y_high = yhi_r;
    res.extent_z_low  = zlo_r;
    res.extent_z_high = zhi_r;
    res.final_result  = cmd.kind;
  end
endmodule

// ===== rtl/core/vcec_ctrl.sv =====
// Controller: sequences load, scan, divide and output for both results.
// Depends on vcec_pkg.
`timescale 1ns / 1ps
module vcec_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_last,
  input  logic                out_stall,
  output logic                out_valid,
  output logic                out_load,
  input  vcec_pkg::dp_stat_t  stat,
  output vcec_pkg::dp_cmd_t   cmd
);
  import vcec_pkg::*;
  typedef enum logic [2:0] {S_LOAD, S_SCAN, S_DRAIN, S_DIV, S_WAIT, S_OUT} state_t;
  state_t state_r, state_nxt;
  logic   kind_r, kind_nxt, out_valid_r, out_valid_nxt;
  logic   acc_r, acc_nxt;
  logic   accept;

  assign in_stall = (state_r != S_LOAD);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r; kind_nxt = kind_r; out_valid_nxt = out_valid_r;
    acc_nxt = 1'b0;
    cmd = '0;
    cmd.kind = kind_r;
    cmd.acc_en = acc_r;
    out_load = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        cmd.load = accept;
        if (accept && in_last) begin
          state_nxt = S_SCAN; kind_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        // first cycle of a scan: read address set to 0, sums cleared
        cmd.scan_start = 1'b1;
        state_nxt = S_DRAIN;
        acc_nxt = 1'b0;
      end
      S_DRAIN: begin
        // rd data of the current address lands next cycle
        acc_nxt = 1'b1;
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!acc_r) begin
          cmd.div_start = 1'b1; state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_OUT; out_valid_nxt = 1'b1; out_load = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (kind_r) begin
            cmd.clear = 1'b1; state_nxt = S_LOAD; kind_nxt = 1'b0;
          end else begin
            kind_nxt = 1'b1; state_nxt = S_SCAN;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; kind_r <= 1'b0; out_valid_r <= 1'b0; acc_r <= 1'b0;
    end else begin
      state_r <= state_nxt; kind_r <= kind_nxt; out_valid_r <= out_valid_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule
